// ===== hdl/sco_pkg.sv =====
// Package for the cursor overlay: register map, configuration struct and shape ROMs.
package sco_pkg;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;
  localparam int CoordW    = 8;
  localparam int PixW      = 8;
  localparam int SightDim  = 13;
  localparam int SightOfs  = 7;
  localparam int ArrowW    = 11;
  localparam int ArrowH    = 19;
  localparam int SightIdxW = $clog2(SightDim * SightDim);
  localparam int ArrowIdxW = $clog2(ArrowW * ArrowH);

  localparam logic [PixW-1:0] ShadeBase = 8'hBF;
  localparam logic [PixW-1:0] ShadeMask = 8'h3F;
  localparam logic [PixW-1:0] ArrowBase = 8'd127;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CROSS_EN = 3'd0,
    CFG_ARROW_EN = 3'd1,
    CFG_GUN_X    = 3'd2,
    CFG_GUN_Y    = 3'd3,
    CFG_ARROW_X  = 3'd4,
    CFG_ARROW_Y  = 3'd5
  } cfg_reg_e;

  typedef logic [1:0] code_t;

  localparam code_t CodeNone  = 2'd0;
  localparam code_t CodeShade = 2'd3;

  typedef struct packed {
    logic              cross_en;
    logic              arrow_en;
    logic [CoordW-1:0] gun_x;
    logic [CoordW-1:0] gun_y;
    logic [CoordW-1:0] arrow_x;
    logic [CoordW-1:0] arrow_y;
  } cfg_t;

  localparam code_t SIGHT_ROM [SightDim*SightDim] = '{
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd2,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd2,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd3,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd1,2'd2,2'd0,2'd3,2'd3,2'd3,2'd0,2'd2,2'd1,2'd2,2'd1,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd3,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd2,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd2,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0
  };

  localparam code_t ARROW_ROM [ArrowW*ArrowH] = '{
    2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,
    2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd1,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,
    2'd1,2'd1,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,
    2'd1,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd1,2'd0,2'd0
  };

endpackage

// ===== hdl/sco_cfg_regs.sv =====
// Configuration register file for the cursor overlay.
module sco_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sco_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sco_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output sco_pkg::cfg_t                    cfg_o
);

  sco_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sco_pkg::cfg_reg_e'(cfg_idx_i))
        sco_pkg::CFG_CROSS_EN: cfg_d.cross_en = cfg_wdata_i[0];
        sco_pkg::CFG_ARROW_EN: cfg_d.arrow_en = cfg_wdata_i[0];
        sco_pkg::CFG_GUN_X:    cfg_d.gun_x    = cfg_wdata_i;
        sco_pkg::CFG_GUN_Y:    cfg_d.gun_y    = cfg_wdata_i;
        sco_pkg::CFG_ARROW_X:  cfg_d.arrow_x  = cfg_wdata_i;
        sco_pkg::CFG_ARROW_Y:  cfg_d.arrow_y  = cfg_wdata_i;
        default:               cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/sco_overlay.sv =====
// Per-pixel crosshair and arrow overlay logic.
module sco_overlay #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 240
) (
  input  sco_pkg::cfg_t                cfg_i,
  input  logic [sco_pkg::CoordW-1:0]   pixel_x_i,
  input  logic [sco_pkg::CoordW-1:0]   pixel_y_i,
  input  logic [sco_pkg::PixW-1:0]     pixel_in_i,
  output logic [sco_pkg::PixW-1:0]     pixel_out_o
);

  localparam int DW = sco_pkg::CoordW + 2;

  logic                              in_frame;
  logic signed [DW-1:0]              cx, cy, ax, ay;
  logic                              sight_hit, arrow_hit, arrow_anchor_ok;
  logic [sco_pkg::SightIdxW-1:0]     sight_idx;
  logic [sco_pkg::ArrowIdxW-1:0]     arrow_idx;
  sco_pkg::code_t                    sight_code, arrow_code;
  logic [sco_pkg::PixW-1:0]          pix;

  assign in_frame = (int'(pixel_x_i) < FRAME_WIDTH) && (int'(pixel_y_i) < FRAME_HEIGHT);
  assign arrow_anchor_ok = (int'(cfg_i.arrow_x) < FRAME_WIDTH) &&
                           (int'(cfg_i.arrow_y) < FRAME_HEIGHT);

  // offsets into the shapes, signed so that clipping on the left/top shows up
  assign cx = signed'({2'b00, pixel_x_i}) - signed'({2'b00, cfg_i.gun_x})
              + DW'(sco_pkg::SightOfs);
  assign cy = signed'({2'b00, pixel_y_i}) - signed'({2'b00, cfg_i.gun_y})
              + DW'(sco_pkg::SightOfs);
  assign ax = signed'({2'b00, pixel_x_i}) - signed'({2'b00, cfg_i.arrow_x});
  assign ay = signed'({2'b00, pixel_y_i}) - signed'({2'b00, cfg_i.arrow_y});

  assign sight_hit = in_frame && cfg_i.cross_en &&
                     (cx >= 0) && (cx < DW'(sco_pkg::SightDim)) &&
                     (cy >= 0) && (cy < DW'(sco_pkg::SightDim));
  assign arrow_hit = in_frame && cfg_i.arrow_en && arrow_anchor_ok &&
                     (ax >= 0) && (ax < DW'(sco_pkg::ArrowW)) &&
                     (ay >= 0) && (ay < DW'(sco_pkg::ArrowH));

  assign sight_idx = sco_pkg::SightIdxW'(cy[3:0]) * sco_pkg::SightIdxW'(sco_pkg::SightDim)
                     + sco_pkg::SightIdxW'(cx[3:0]);
  assign arrow_idx = sco_pkg::ArrowIdxW'(ay[4:0]) * sco_pkg::ArrowIdxW'(sco_pkg::ArrowW)
                     + sco_pkg::ArrowIdxW'(ax[3:0]);

  assign sight_code = sight_hit ? sco_pkg::SIGHT_ROM[sight_idx] : sco_pkg::CodeNone;
  assign arrow_code = arrow_hit ? sco_pkg::ARROW_ROM[arrow_idx] : sco_pkg::CodeNone;

  always_comb begin
    pix = pixel_in_i;
    if (sight_code == sco_pkg::CodeShade) begin
      pix = sco_pkg::ShadeBase - (pixel_in_i & sco_pkg::ShadeMask);
    end else if (sight_code != sco_pkg::CodeNone) begin
      pix = {6'b0, sight_code} - 8'd1;
    end
    if (arrow_code != sco_pkg::CodeNone) begin
      pix = {6'b0, arrow_code} + sco_pkg::ArrowBase;
    end
  end

  assign pixel_out_o = pix;

endmodule

// ===== hdl/sprite_cursor_overlay.sv =====
// Pipeline: an accepted request is held in the input register and then in the output register,
// which presents it. Throughput: one pixel per cycle while the sink does not stall; the two
// registers split the path, so a new pixel is taken while a result waits downstream.
// Reset: asynchronous active-low; pipeline valids clear and all registers read zero,
// so both cursor layers start disabled.
module sprite_cursor_overlay #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sco_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sco_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // pixel_x, pixel_y, pixel_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata   // pixel_out
);

  sco_pkg::cfg_t cfg;

  logic        in_vld_q, in_vld_d;
  logic [23:0] in_data_q;
  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_data_q;
  logic [7:0]  pix_res;
  logic        adv;
  logic        take;

  sco_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sco_overlay #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_overlay (
    .cfg_i       (cfg),
    .pixel_x_i   (in_data_q[7:0]),
    .pixel_y_i   (in_data_q[15:8]),
    .pixel_in_i  (in_data_q[23:16]),
    .pixel_out_o (pix_res)
  );

  // output stage free or draining this cycle
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = adv ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      in_data_q  <= '0;
      out_data_q <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (take) begin
        in_data_q <= s_axis_tdata;
      end
      if (adv && in_vld_q) begin
        out_data_q <= pix_res;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== verif/cursor_overlay_checker.sv =====
// Checker for the cursor overlay: predicts each output pixel and compares it with the DUT.
module cursor_overlay_checker #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sco_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sco_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [23:0]                  s_tdata_i,   // pixel_x, pixel_y, pixel_in
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [7:0]                   m_tdata_i,   // pixel_out
  output int unsigned                  fail_cnt_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [sco_pkg::CoordW-1:0] x;
    logic [sco_pkg::CoordW-1:0] y;
    logic [sco_pkg::PixW-1:0]   pin;
    logic [sco_pkg::PixW-1:0]   pout;
  } pixel_req_t;

  sco_pkg::cfg_t shadow_cfg;
  pixel_req_t    pixel_out_q[$];
  pixel_req_t    req;
  pixel_req_t    want;

  function automatic logic [sco_pkg::PixW-1:0] overlay_pixel(
      sco_pkg::cfg_t c, logic [sco_pkg::CoordW-1:0] px,
      logic [sco_pkg::CoordW-1:0] py, logic [sco_pkg::PixW-1:0] pin);
    int                       cx;
    int                       cy;
    int                       ax;
    int                       ay;
    sco_pkg::code_t           code;
    logic [sco_pkg::PixW-1:0] res;
    res = pin;
    if (int'(px) < FRAME_WIDTH && int'(py) < FRAME_HEIGHT) begin
      if (c.cross_en) begin
        cx = int'(px) - int'(c.gun_x) + sco_pkg::SightOfs;
        cy = int'(py) - int'(c.gun_y) + sco_pkg::SightOfs;
        if (cx >= 0 && cx < sco_pkg::SightDim && cy >= 0 && cy < sco_pkg::SightDim) begin
          code = sco_pkg::SIGHT_ROM[cy*sco_pkg::SightDim + cx];
          if (code == sco_pkg::CodeShade) begin
            res = sco_pkg::ShadeBase - (pin & sco_pkg::ShadeMask);
          end else if (code != sco_pkg::CodeNone) begin
            res = {6'd0, code} - 8'd1;
          end
        end
      end
      if (c.arrow_en && int'(c.arrow_x) < FRAME_WIDTH && int'(c.arrow_y) < FRAME_HEIGHT) begin
        ax = int'(px) - int'(c.arrow_x);
        ay = int'(py) - int'(c.arrow_y);
        if (ax >= 0 && ax < sco_pkg::ArrowW && ay >= 0 && ay < sco_pkg::ArrowH) begin
          code = sco_pkg::ARROW_ROM[ay*sco_pkg::ArrowW + ax];
          if (code != sco_pkg::CodeNone) res = sco_pkg::ArrowBase + {6'd0, code};
        end
      end
    end
    return res;
  endfunction

  task automatic flag_error(string msg);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) $display("%t %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg = '0;
      pixel_out_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (sco_pkg::cfg_reg_e'(cfg_idx_i))
          sco_pkg::CFG_CROSS_EN: shadow_cfg.cross_en = cfg_wdata_i[0];
          sco_pkg::CFG_ARROW_EN: shadow_cfg.arrow_en = cfg_wdata_i[0];
          sco_pkg::CFG_GUN_X:    shadow_cfg.gun_x    = cfg_wdata_i;
          sco_pkg::CFG_GUN_Y:    shadow_cfg.gun_y    = cfg_wdata_i;
          sco_pkg::CFG_ARROW_X:  shadow_cfg.arrow_x  = cfg_wdata_i;
          sco_pkg::CFG_ARROW_Y:  shadow_cfg.arrow_y  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        req.x    = s_tdata_i[7:0];
        req.y    = s_tdata_i[15:8];
        req.pin  = s_tdata_i[23:16];
        req.pout = overlay_pixel(shadow_cfg, req.x, req.y, req.pin);
        pixel_out_q.push_back(req);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pixel_out_q.size() == 0) begin
          flag_error($sformatf("unexpected pixel_out %0d with no request pending", m_tdata_i));
        end else begin
          want = pixel_out_q.pop_front();
          if (want.pout !== m_tdata_i) begin
            flag_error($sformatf("pixel (%0d,%0d) in %0d: pixel_out expected %0d got %0d",
                                 want.x, want.y, want.pin, want.pout, m_tdata_i));
          end
        end
      end
      pending_o = pixel_out_q.size();
    end
  end

endmodule

// ===== verif/tb_sprite_cursor_overlay.sv =====
// Testbench top for the cursor overlay: clock, reset, stimulus and the final verdict.
module tb_sprite_cursor_overlay;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameW   = 256;
  localparam int FrameH   = 240;
  localparam int DrainGap = 4;
  localparam logic [sco_pkg::CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [sco_pkg::CfgIdxW-1:0] CfgSpareHi = 3'd7;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [sco_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [sco_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [23:0]                  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [7:0]                   m_axis_tdata;

  int unsigned fail_cnt;
  int unsigned pending;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          sink_hold;
  logic [7:0]  cur_gx, cur_gy, cur_ax, cur_ay;

  sprite_cursor_overlay #(
    .FRAME_WIDTH (FrameW),
    .FRAME_HEIGHT(FrameH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  cursor_overlay_checker #(
    .FRAME_WIDTH (FrameW),
    .FRAME_HEIGHT(FrameH)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #2_400_000;
    $display("tb_sprite_cursor_overlay: FAIL");
    $finish;
  end

  // sink side: random stalls plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic push_pixel(input logic [7:0] x, input logic [7:0] y, input logic [7:0] pin);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pin, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainGap) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [sco_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic ce, input logic ae, input logic [7:0] gx,
                                input logic [7:0] gy, input logic [7:0] ax,
                                input logic [7:0] ay, input bit spare);
    wait_drained();
    write_reg(sco_pkg::CFG_CROSS_EN, {7'd0, ce});
    write_reg(sco_pkg::CFG_ARROW_EN, {7'd0, ae});
    write_reg(sco_pkg::CFG_GUN_X, gx);
    write_reg(sco_pkg::CFG_GUN_Y, gy);
    write_reg(sco_pkg::CFG_ARROW_X, ax);
    write_reg(sco_pkg::CFG_ARROW_Y, ay);
    if (spare) begin
      write_reg(CfgSpareLo, 8'hFF);
      write_reg(CfgSpareHi, 8'hFF);
    end
    cfg_we_i <= 1'b0;
    cur_gx = gx;
    cur_gy = gy;
    cur_ax = ax;
    cur_ay = ay;
  endtask

  initial begin
    logic [7:0] gx, gy, ax, ay, px, py;
    int         sel;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold      = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: both layers on, shapes well apart
    apply_settings(1'b1, 1'b1, 8'd20, 8'd20, 8'd100, 8'd100, 1'b0);
    push_pixel(8'd19, 8'd19, 8'h00);   // crosshair center, shade
    push_pixel(8'd19, 8'd19, 8'hFF);
    push_pixel(8'd18, 8'd19, 8'h55);   // shade arm
    push_pixel(8'd13, 8'd19, 8'h77);   // code 1, left tip
    push_pixel(8'd14, 8'd19, 8'h77);   // code 2
    push_pixel(8'd19, 8'd13, 8'h42);   // code 1, top tip
    push_pixel(8'd19, 8'd14, 8'h42);   // code 2
    push_pixel(8'd17, 8'd19, 8'h99);   // gap in horizontal arm
    push_pixel(8'd25, 8'd25, 8'h11);   // blank corner of the box
    push_pixel(8'd26, 8'd19, 8'h22);   // just right of the box
    push_pixel(8'd100, 8'd100, 8'h33); // arrow tip, code 1
    push_pixel(8'd101, 8'd102, 8'h33); // arrow fill, code 2
    push_pixel(8'd110, 8'd100, 8'h44); // arrow blank
    push_pixel(8'd110, 8'd110, 8'h44); // arrow right tail
    push_pixel(8'd108, 8'd118, 8'h55); // arrow bottom row
    push_pixel(8'd109, 8'd118, 8'h55);
    push_pixel(8'd111, 8'd100, 8'h66); // just right of the arrow
    push_pixel(8'd0, 8'd0, 8'h00);
    push_pixel(8'd255, 8'd239, 8'hFF);
    push_pixel(8'd19, 8'd240, 8'hA5);  // row below the frame
    push_pixel(8'd0, 8'd255, 8'h5A);
    push_pixel(8'd255, 8'd255, 8'hC3);

    for (int ph = 1; ph <= 8; ph++) begin
      gx = 8'($urandom_range(255));
      gy = 8'($urandom_range(239));
      ax = 8'($urandom_range(255));
      ay = 8'($urandom_range(239));
      case (ph)
        1: apply_settings(1'b1, 1'b1, gx, gy, ax, ay, 1'b0);
        2: apply_settings(1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        3: apply_settings(1'b1, 1'b1, 8'd255, 8'd239, 8'd250, 8'd235, 1'b0);
        4: apply_settings(1'b1, 1'b1, gx, gy, ax, 8'(240 + $urandom_range(15)), 1'b0);
        5: apply_settings(1'b1, 1'b0, 8'd255, 8'd255, 8'd255, 8'd239, 1'b1);
        6: apply_settings(1'b0, 1'b0, gx, gy, ax, ay, 1'b0);
        7: apply_settings(1'b1, 1'b1, gx, gy, gx - 8'd3, gy - 8'd3, 1'b0);
        default: apply_settings(1'b0, 1'b1, gx, 8'($urandom_range(255)), ax, ay, 1'b0);
      endcase
      case ((ph - 1) % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 71; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 71; end
        default: begin src_idle_pct = 26; sink_stall_pct = 26; end
      endcase
      for (int n = 0; n < 85; n++) begin
        if (ph == 1 && n == 10) sink_hold = 60;
        if (ph == 2 && n == 40) wait_drained();
        sel = $urandom_range(99);
        if (sel < 40) begin
          px = cur_gx - 8'd7 + 8'($urandom_range(12));
          py = cur_gy - 8'd7 + 8'($urandom_range(12));
        end else if (sel < 75) begin
          px = cur_ax + 8'($urandom_range(10));
          py = cur_ay + 8'($urandom_range(18));
        end else begin
          px = 8'($urandom_range(255));
          py = 8'($urandom_range(255));
        end
        push_pixel(px, py, 8'($urandom_range(255)));
      end
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_sprite_cursor_overlay: PASS");
    end else begin
      $display("tb_sprite_cursor_overlay: FAIL");
    end
    $finish;
  end

endmodule
